### src/rptmf_pkg.sv
// shared types, constants and helpers for the rc pulse trimmed mean filter
// no dependencies; rptmf_rmw, rptmf_shape and the top level refer to it by scoped names
package rptmf_pkg;

    // field widths
    localparam int CW     = 3;     // channel number
    localparam int PW     = 16;    // raw pulse width
    localparam int VW     = 12;    // accepted and filtered values
    localparam int WINDOW = 4;     // ring entries per channel
    localparam int SLOTW  = 2;     // ring pointer
    localparam int SUMW   = VW + SLOTW;
    localparam int CFG_IW = 2;     // config register index

    // defaults
    localparam int CHANNELS_DEFAULT = 8;

    // register reset values
    localparam logic [VW-1:0] REJECT_LOW_RST    = 12'd800;
    localparam logic [VW-1:0] REJECT_HIGH_RST   = 12'd2800;
    localparam logic [VW-1:0] THROTTLE_KNEE_RST = 12'd1000;

    // config register indexes
    localparam logic [CFG_IW-1:0] CFG_REJECT_LOW    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_REJECT_HIGH   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_THROTTLE_KNEE = 2'd2;

    // the throttle channel and the channel pair that swaps slots
    localparam logic [CW-1:0] THROTTLE_CH = 3'd2;
    localparam logic [CW-1:0] SWAP_CH_A   = 3'd2;
    localparam logic [CW-1:0] SWAP_CH_B   = 3'd3;

    // floor(n / 5) as (n * RECIP5) >> RECIP5_SHIFT, exact for n below 2**16
    localparam int RECIP5_W     = 16;
    localparam logic [RECIP5_W-1:0] RECIP5 = 16'd52429;
    localparam int RECIP5_SHIFT = 18;

    typedef struct packed {
        logic [CW-1:0] channel;
        logic [PW-1:0] pulse_width;
    } in_item_t;

    typedef struct packed {
        logic [CW-1:0] channel_echo;
        logic [CW-1:0] slot;
        logic          rejected;
        logic [VW-1:0] filtered;
        logic [VW-1:0] shaped;
    } out_item_t;

    // one memory word: held value, ring pointer and ring entries of one channel
    typedef struct packed {
        logic [VW-1:0]              held;
        logic [SLOTW-1:0]           wslot;
        logic [WINDOW-1:0][VW-1:0]  entry;
    } row_t;

    // hand-off from the update stage to the math pipeline
    typedef struct packed {
        logic [CW-1:0]              channel;
        logic                       rejected;
        logic [WINDOW-1:0][VW-1:0]  entry;
    } trim_in_t;

    function automatic logic [CW-1:0] remap_slot(input logic [CW-1:0] ch);
        logic [CW-1:0] r;
        r = ch;
        if (ch == SWAP_CH_A) r = SWAP_CH_B;
        if (ch == SWAP_CH_B) r = SWAP_CH_A;
        return r;
    endfunction

endpackage

### src/rptmf_ram.sv
// generic single-write, single-read ram with registered read data
// read-first on an address collision; no dependencies
module rptmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/rptmf_rmw.sv
// modify step of the channel row: reject substitution, pointer advance, ring insert
// depends on rptmf_pkg
module rptmf_rmw (
    input  rptmf_pkg::row_t          old_row,
    input  logic                     rejected,
    input  logic [rptmf_pkg::VW-1:0] width_in,
    output rptmf_pkg::row_t          new_row
);

    logic [rptmf_pkg::VW-1:0]    w_acc;
    logic [rptmf_pkg::SLOTW-1:0] next_slot;

    // replaced widths take the held value
    assign w_acc     = rejected ? old_row.held : width_in;
    // pointer advances before the write, so the first write lands in slot 1
    assign next_slot = old_row.wslot + rptmf_pkg::SLOTW'(1);

    always_comb begin
        new_row                  = old_row;
        new_row.held             = w_acc;
        new_row.wslot            = next_slot;
        new_row.entry[next_slot] = w_acc;
    end

endmodule

### src/rptmf_shape.sv
// math pipeline: trimmed mean, throttle excess times three, divide by five and add knee
// depends on rptmf_pkg
module rptmf_shape (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  rptmf_pkg::trim_in_t      in_data,
    input  logic [rptmf_pkg::VW-1:0] throttle_knee,
    output logic                     m_valid,
    input  logic                     m_ready,
    output rptmf_pkg::out_item_t     m_item
);

    localparam int PRODW = rptmf_pkg::SUMW + rptmf_pkg::RECIP5_W;

    // stage a: trimmed mean
    logic                       a_valid_reg;
    logic [rptmf_pkg::CW-1:0]   a_ch_reg;
    logic                       a_rej_reg;
    logic [rptmf_pkg::VW-1:0]   a_filt_reg;
    // stage b: gain decision and three times the excess
    logic                       b_valid_reg;
    logic [rptmf_pkg::CW-1:0]   b_ch_reg;
    logic                       b_rej_reg;
    logic [rptmf_pkg::VW-1:0]   b_filt_reg;
    logic                       b_apply_reg;
    logic [rptmf_pkg::SUMW-1:0] b_p3_reg;
    // output register
    logic                       m_valid_reg;
    rptmf_pkg::out_item_t       m_item_reg;

    logic                       a_ready, b_ready, c_ready;
    logic [rptmf_pkg::VW-1:0]   filt_next;
    logic [rptmf_pkg::VW-1:0]   excess;
    logic [rptmf_pkg::SUMW-1:0] p3_next;
    logic [PRODW-1:0]           quot_prod;
    logic [rptmf_pkg::VW-1:0]   shaped_next;

    assign c_ready  = !m_valid_reg || m_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // sum of the ring minus its largest and smallest entry, halved
    always_comb begin
        logic [rptmf_pkg::VW-1:0]   mx;
        logic [rptmf_pkg::VW-1:0]   mn;
        logic [rptmf_pkg::SUMW-1:0] sum;
        mx  = '0;
        mn  = '1;
        sum = '0;
        for (int i = 0; i < rptmf_pkg::WINDOW; i++) begin
            if (in_data.entry[i] > mx) mx = in_data.entry[i];
            if (in_data.entry[i] < mn) mn = in_data.entry[i];
            sum = sum + rptmf_pkg::SUMW'(in_data.entry[i]);
        end
        sum       = sum - rptmf_pkg::SUMW'(mx) - rptmf_pkg::SUMW'(mn);
        filt_next = sum[rptmf_pkg::VW:1];
    end

    // excess over the knee, times three by shift and add
    assign excess  = a_filt_reg - throttle_knee;
    assign p3_next = {excess, 1'b0} + rptmf_pkg::SUMW'(excess);

    // divide by five through the reciprocal
    assign quot_prod   = PRODW'(b_p3_reg) * PRODW'(rptmf_pkg::RECIP5);
    assign shaped_next = b_apply_reg
                       ? throttle_knee + quot_prod[rptmf_pkg::RECIP5_SHIFT +: rptmf_pkg::VW]
                       : b_filt_reg;

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (a_ready) a_valid_reg <= in_valid;
            if (b_ready) b_valid_reg <= a_valid_reg;
            if (c_ready) m_valid_reg <= b_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (in_valid && a_ready) begin
            a_ch_reg   <= in_data.channel;
            a_rej_reg  <= in_data.rejected;
            a_filt_reg <= filt_next;
        end
        if (a_valid_reg && b_ready) begin
            b_ch_reg    <= a_ch_reg;
            b_rej_reg   <= a_rej_reg;
            b_filt_reg  <= a_filt_reg;
            b_apply_reg <= (a_ch_reg == rptmf_pkg::THROTTLE_CH)
                        && (a_filt_reg > throttle_knee);
            b_p3_reg    <= p3_next;
        end
        if (b_valid_reg && c_ready) begin
            m_item_reg.channel_echo <= b_ch_reg;
            m_item_reg.slot         <= rptmf_pkg::remap_slot(b_ch_reg);
            m_item_reg.rejected     <= b_rej_reg;
            m_item_reg.filtered     <= b_filt_reg;
            m_item_reg.shaped       <= shaped_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### src/rc_pulse_trimmed_mean_filter.sv
// top level of the rc pulse trimmed mean filter: config registers, row memory, update stage
// depends on rptmf_pkg, rptmf_ram, rptmf_rmw and rptmf_shape
//
//  channel | ports                        | payload
//  --------+------------------------------+------------------------------------------
//  input   | s_valid, s_ready, s_item     | channel, pulse_width
//  result  | m_valid, m_ready, m_item     | channel_echo, slot, rejected, filtered, shaped
//  config  | cfg_valid, cfg_ready         | cfg_index (0 low, 1 high, 2 knee), cfg_data
//
//  one transaction per cycle each way unless stalled; a result crosses s1, a, b, out regs
//  the per-channel row is read when the input is taken and written back as the item leaves s1;
//  a back-to-back pair on one channel gets the written row forwarded past the memory
//  reset restores the register defaults and clears one valid bit per row, no clearing pass
//  a stall on the result side holds the pipeline and drops s_ready; config is always ready
module rc_pulse_trimmed_mean_filter #(
    parameter int CHANNELS = rptmf_pkg::CHANNELS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  rptmf_pkg::in_item_t          s_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output rptmf_pkg::out_item_t         m_item,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rptmf_pkg::CFG_IW-1:0] cfg_index,
    input  logic [rptmf_pkg::VW-1:0]     cfg_data
);

    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ROW_W = $bits(rptmf_pkg::row_t);

    // configuration registers
    logic [rptmf_pkg::VW-1:0] reject_low_reg;
    logic [rptmf_pkg::VW-1:0] reject_high_reg;
    logic [rptmf_pkg::VW-1:0] throttle_knee_reg;

    // update stage
    logic                       s1_valid_reg;
    logic [rptmf_pkg::CW-1:0]   s1_ch_reg;
    logic [AW-1:0]              s1_addr_reg;
    logic                       s1_in_range_reg;
    logic                       s1_rej_reg;
    logic [rptmf_pkg::VW-1:0]   s1_width_reg;
    logic                       s1_fwd_hit_reg;
    rptmf_pkg::row_t            s1_fwd_row_reg;
    logic                       s1_row_valid_reg;
    logic [CHANNELS-1:0]        row_valid_reg;

    logic [AW+rptmf_pkg::CW-1:0] ch_wide;
    logic [AW-1:0]               rd_addr;
    logic                        in_range;
    logic                        reject;
    logic                        accept;
    logic                        wr_en;
    logic [ROW_W-1:0]            rd_data;
    rptmf_pkg::row_t             old_row;
    rptmf_pkg::row_t             new_row;
    rptmf_pkg::trim_in_t         trim_in;
    logic                        shape_ready;

    assign cfg_ready = 1'b1;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reject_low_reg    <= rptmf_pkg::REJECT_LOW_RST;
            reject_high_reg   <= rptmf_pkg::REJECT_HIGH_RST;
            throttle_knee_reg <= rptmf_pkg::THROTTLE_KNEE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rptmf_pkg::CFG_REJECT_LOW:    reject_low_reg    <= cfg_data;
                rptmf_pkg::CFG_REJECT_HIGH:   reject_high_reg   <= cfg_data;
                rptmf_pkg::CFG_THROTTLE_KNEE: throttle_knee_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input decode: row address, range check, reject test
    assign ch_wide  = (AW + rptmf_pkg::CW)'(s_item.channel);
    assign rd_addr  = ch_wide[AW-1:0];
    assign in_range = {29'd0, s_item.channel} < 32'(CHANNELS);
    assign reject   = (s_item.pulse_width > rptmf_pkg::PW'(reject_high_reg))
                   || (s_item.pulse_width < rptmf_pkg::PW'(reject_low_reg));

    assign s_ready = !s1_valid_reg || shape_ready;
    assign accept  = s_valid && s_ready;

    // write back as the item leaves the update stage
    assign wr_en = s1_valid_reg && shape_ready && s1_in_range_reg;

    rptmf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CHANNELS)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (ROW_W'(new_row)),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // update stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            row_valid_reg <= '0;
        end else begin
            if (s_ready) s1_valid_reg <= s_valid;
            if (wr_en) row_valid_reg[s1_addr_reg] <= 1'b1;
        end
    end

    // update stage payload, with forwarding of a row written at the read edge
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ch_reg        <= s_item.channel;
            s1_addr_reg      <= rd_addr;
            s1_in_range_reg  <= in_range;
            s1_rej_reg       <= in_range && reject;
            s1_width_reg     <= s_item.pulse_width[rptmf_pkg::VW-1:0];
            s1_fwd_hit_reg   <= wr_en && (s1_addr_reg == rd_addr);
            s1_fwd_row_reg   <= new_row;
            s1_row_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    // current row: forwarded, stored, or zero before the first write
    always_comb begin
        if (s1_fwd_hit_reg) begin
            old_row = s1_fwd_row_reg;
        end else if (s1_row_valid_reg) begin
            old_row = rptmf_pkg::row_t'(rd_data);
        end else begin
            old_row = '0;
        end
    end

    rptmf_rmw u_rmw (
        .old_row  (old_row),
        .rejected (s1_rej_reg),
        .width_in (s1_width_reg),
        .new_row  (new_row)
    );

    // channels beyond the count leave zero values for the math
    always_comb begin
        trim_in.channel  = s1_ch_reg;
        trim_in.rejected = s1_rej_reg;
        trim_in.entry    = s1_in_range_reg ? new_row.entry : '0;
    end

    rptmf_shape u_shape (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s1_valid_reg),
        .in_ready      (shape_ready),
        .in_data       (trim_in),
        .throttle_knee (throttle_knee_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item)
    );

    // checks
    a_stall_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s1_valid_reg)
        else $error("input stalled with an empty update stage");

    a_row_marked_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> row_valid_reg[$past(s1_addr_reg)])
        else $error("written row not marked valid");

    a_no_write_out_of_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_in_range_reg) |-> !wr_en && !s1_rej_reg)
        else $error("state touched for a channel beyond the count");

endmodule
